### sv/lts_pkg.sv
// shared types, character codes and helpers for the lexical token scanner
`default_nettype none

package lts_pkg;

    // line counter width
    localparam int LINE_BITS = 16;
    // width of the reported line number field
    localparam int OUT_LINE_BITS = 16;

    // token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_INT   = 2'd1,
        ST_IDENT = 2'd2,
        ST_COLON = 2'd3
    } t_scan_state;

    typedef enum logic [3:0] {
        TK_IDENT  = 4'd0,
        TK_INT    = 4'd1,
        TK_ASSIGN = 4'd2,
        TK_PLUS   = 4'd3,
        TK_TIMES  = 4'd4,
        TK_LPAREN = 4'd5,
        TK_RPAREN = 4'd6,
        TK_SEMI   = 4'd7,
        TK_MINUS  = 4'd8,
        TK_ERROR  = 4'd9,
        TK_END    = 4'd10
    } t_token_kind;

    // one or two tokens caused by one byte; both carry the same line
    typedef struct packed {
        t_token_kind               kind0;
        t_token_kind               kind1;
        logic                      two;
        logic [OUT_LINE_BITS-1:0]  line;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // low bits of the line counter, zero extended where the counter is narrow
    function automatic logic [OUT_LINE_BITS-1:0] to_out_line(
        input logic [LINE_BITS-1:0] count
    );
        logic [LINE_BITS+OUT_LINE_BITS-1:0] wide;
        wide = {{OUT_LINE_BITS{1'b0}}, count};
        return wide[OUT_LINE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/lts_front.sv
// front end: takes bytes, runs the scanner state machine, pushes tokens
`default_nettype none

module lts_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [7:0]                         i_char_code,
    input  wire logic                               i_end_of_input,
    input  wire logic                               i_q_full,
    output lts_pkg::t_push                          o_push
);

    lts_pkg::t_scan_state            r_state, n_state;
    logic [lts_pkg::LINE_BITS-1:0]   r_line, n_line;

    logic                  accept;
    logic                  ends, is_dig, is_alpha, is_space;
    logic                  run_idle;
    logic                  pend_v, own_v;
    lts_pkg::t_token_kind  pend_k, own_k;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lts_pkg::ST_IDLE;
            r_line  <= lts_pkg::LINE_ONE;
        end else if (accept) begin
            r_state <= n_state;
            r_line  <= n_line;
        end
    end

    always_comb begin
        ends     = i_end_of_input || (i_char_code == lts_pkg::CH_NUL);
        is_dig   = i_char_code inside {[lts_pkg::CH_0:lts_pkg::CH_9]};
        is_alpha = i_char_code inside {[lts_pkg::CH_LO_A:lts_pkg::CH_LO_Z],
                                       [lts_pkg::CH_UP_A:lts_pkg::CH_UP_Z]};
        is_space = (i_char_code == lts_pkg::CH_SPACE) ||
                   (i_char_code inside {[lts_pkg::CH_TAB:lts_pkg::CH_CR]});

        run_idle = 1'b1;
        pend_v   = 1'b0;
        pend_k   = lts_pkg::TK_ERROR;
        own_v    = 1'b0;
        own_k    = lts_pkg::TK_ERROR;
        n_state  = r_state;
        n_line   = r_line;

        // close any pending token
        case (r_state)
            lts_pkg::ST_INT: begin
                if (!ends && is_dig) begin
                    run_idle = 1'b0;
                end else begin
                    pend_v = 1'b1;
                    pend_k = lts_pkg::TK_INT;
                end
            end
            lts_pkg::ST_IDENT: begin
                if (!ends && (is_alpha || is_dig)) begin
                    run_idle = 1'b0;
                end else begin
                    pend_v = 1'b1;
                    pend_k = lts_pkg::TK_IDENT;
                end
            end
            lts_pkg::ST_COLON: begin
                pend_v = 1'b1;
                if (!ends && (i_char_code == lts_pkg::CH_EQUAL)) begin
                    run_idle = 1'b0;
                    pend_k   = lts_pkg::TK_ASSIGN;
                    n_state  = lts_pkg::ST_IDLE;
                end else begin
                    pend_k = lts_pkg::TK_ERROR;
                end
            end
            default: ;
        endcase

        // reprocess the byte from idle
        if (run_idle) begin
            n_state = lts_pkg::ST_IDLE;
            if (ends) begin
                own_v  = 1'b1;
                own_k  = lts_pkg::TK_END;
                n_line = lts_pkg::LINE_ONE;
            end else if (is_space) begin
                if ((i_char_code == lts_pkg::CH_NL) && (r_line != lts_pkg::LINE_MAX)) begin
                    n_line = r_line + lts_pkg::LINE_ONE;
                end
            end else if (is_dig) begin
                n_state = lts_pkg::ST_INT;
            end else if (is_alpha) begin
                n_state = lts_pkg::ST_IDENT;
            end else if (i_char_code == lts_pkg::CH_COLON) begin
                n_state = lts_pkg::ST_COLON;
            end else begin
                own_v = 1'b1;
                case (i_char_code)
                    lts_pkg::CH_PLUS:  own_k = lts_pkg::TK_PLUS;
                    lts_pkg::CH_STAR:  own_k = lts_pkg::TK_TIMES;
                    lts_pkg::CH_LPAR:  own_k = lts_pkg::TK_LPAREN;
                    lts_pkg::CH_RPAR:  own_k = lts_pkg::TK_RPAREN;
                    lts_pkg::CH_SEMI:  own_k = lts_pkg::TK_SEMI;
                    lts_pkg::CH_MINUS: own_k = lts_pkg::TK_MINUS;
                    default:           own_k = lts_pkg::TK_ERROR;
                endcase
            end
        end

        o_push.valid       = accept && (pend_v || own_v);
        o_push.entry.line  = lts_pkg::to_out_line(r_line);
        if (pend_v) begin
            o_push.entry.kind0 = pend_k;
            o_push.entry.kind1 = own_k;
            o_push.entry.two   = own_v;
        end else begin
            o_push.entry.kind0 = own_k;
            o_push.entry.kind1 = own_k;
            o_push.entry.two   = 1'b0;
        end
    end

    // end of input always leaves the scanner idle on line one
    a_end_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ends) |=> (r_state == lts_pkg::ST_IDLE) && (r_line == lts_pkg::LINE_ONE))
        else $error("scanner not reset by end of input");

endmodule

`default_nettype wire

### sv/lts_queue.sv
// small token queue between the front and back ends
`default_nettype none

module lts_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lts_pkg::t_push i_push,
    input  wire logic          i_pop,
    output logic               o_full,
    output lts_pkg::t_head     o_head
);

    lts_pkg::t_entry                  r_mem [lts_pkg::QUEUE_DEPTH];
    logic [lts_pkg::QPTR_BITS-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [lts_pkg::QCNT_BITS-1:0]    r_count, n_count;
    logic                             do_pop;

    localparam logic [lts_pkg::QPTR_BITS-1:0] PTR_LAST =
        lts_pkg::QPTR_BITS'(lts_pkg::QUEUE_DEPTH - 1);
    localparam logic [lts_pkg::QPTR_BITS-1:0] PTR_ONE = lts_pkg::QPTR_BITS'(1);
    localparam logic [lts_pkg::QCNT_BITS-1:0] CNT_FULL =
        lts_pkg::QCNT_BITS'(lts_pkg::QUEUE_DEPTH);
    localparam logic [lts_pkg::QCNT_BITS-1:0] CNT_ONE = lts_pkg::QCNT_BITS'(1);

    assign o_full       = (r_count == CNT_FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.valid) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_ONE;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_ONE;
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + CNT_ONE;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("push into full token queue");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("token queue count out of range");

endmodule

`default_nettype wire

### sv/lts_back.sv
// back end: unpacks queued tokens one per cycle into the output register while i_ready is high
`default_nettype none

module lts_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lts_pkg::t_head                      i_head,
    output logic                                     o_pop,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [3:0]                               o_token_kind,
    output logic [lts_pkg::OUT_LINE_BITS-1:0]        o_line_number,
    output logic                                     o_last
);

    logic                                   r_valid, n_valid;
    logic                                   r_half, n_half;
    lts_pkg::t_token_kind                   r_kind, n_kind;
    logic [lts_pkg::OUT_LINE_BITS-1:0]      r_line, n_line;
    logic                                   r_last, n_last;
    logic                                   load;

    always_comb begin
        load    = i_head.valid && (!r_valid || i_ready);
        n_valid = r_valid && !i_ready;
        n_half  = r_half;
        n_kind  = r_kind;
        n_line  = r_line;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            n_kind  = r_half ? i_head.entry.kind1 : i_head.entry.kind0;
            n_line  = i_head.entry.line;
            n_last  = !i_head.entry.two || r_half;
            o_pop   = n_last;
            n_half  = !n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_line <= n_line;
        r_last <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_token_kind  = r_kind;
    assign o_line_number = r_line;
    assign o_last        = r_last;

    // second half of a pair is only pending while its entry is still at the head
    a_half_has_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_head.valid && i_head.entry.two))
        else $error("pending second token without queue entry");

    a_not_last_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_half)
        else $error("first of two tokens shown without second pending");

endmodule

`default_nettype wire

### sv/lexical_token_scanner.sv
// top level of the lexical token scanner: front end, token queue, back end
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_ready    i_char_code, i_end_of_input
//  output   out        o_valid / i_ready    o_token_kind, o_line_number, o_last
//
// one byte is taken per cycle while the token queue has room (4 entries)
// a byte enters the queue at its accept edge; its first token then reaches
// o_valid through the back end output register once that register is free
// a byte that closes a pending token and also makes its own yields two tokens in
// one entry; output sets the rate, one token per cycle while i_ready is high
// reset returns the scanner to idle on line 1 and empties the queue
`default_nettype none

module lexical_token_scanner (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // byte transactions
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [7:0]                          i_char_code,
    input  wire logic                                i_end_of_input,
    // token transactions
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [3:0]                               o_token_kind,
    output logic [lts_pkg::OUT_LINE_BITS-1:0]        o_line_number,
    output logic                                     o_last
);

    // one or two tokens per byte travel as a single queue entry
    lts_pkg::t_push  push;
    lts_pkg::t_head  head;
    logic            q_full;
    logic            pop;

    // classifies each byte and tracks the pending token and line count
    lts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    // decouples byte intake from token delivery stalls
    lts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // splits entries into single token transactions and marks the last one
    lts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_line_number (o_line_number),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
// self-checking testbench for the lexical token scanner
`default_nettype none

module testbench;

    // one expected token transaction
    typedef struct packed {
        lts_pkg::t_token_kind              kind;
        logic [lts_pkg::OUT_LINE_BITS-1:0] line;
        logic                              last;
    } t_token;

    // one row of the directed stimulus; typed rows carry their own single token
    typedef struct packed {
        logic [7:0]                        chr;
        logic                              eoi;
        logic                              typed;
        lts_pkg::t_token_kind              kind;
        logic [lts_pkg::OUT_LINE_BITS-1:0] line;
    } t_dir_row;

    localparam int N_DIRECTED = 27;
    localparam int N_RANDOM   = 650;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [7:0]                        i_char_code;
    logic                              i_end_of_input;
    logic                              o_valid;
    logic                              i_ready;
    logic [3:0]                        o_token_kind;
    logic [lts_pkg::OUT_LINE_BITS-1:0] o_line_number;
    logic                              o_last;

    lexical_token_scanner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_line_number  (o_line_number),
        .o_last         (o_last)
    );

    // scanner state as the testbench sees it
    lts_pkg::t_scan_state          scan_st;
    logic [lts_pkg::LINE_BITS-1:0] line_ct;

    t_token   pending_tokens [$];
    t_token   want;
    t_dir_row directed_rows [0:N_DIRECTED-1];
    int       mismatches;
    int       bytes_sent;
    bit       src_idle_en;
    bit       snk_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= lts_pkg::CH_0 && c <= lts_pkg::CH_9;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= lts_pkg::CH_LO_A && c <= lts_pkg::CH_LO_Z) ||
               (c >= lts_pkg::CH_UP_A && c <= lts_pkg::CH_UP_Z);
    endfunction

    // advance the scanner state by one byte; returns the number of tokens
    function automatic int scan_byte(input logic [7:0] c, input logic e,
                                     output lts_pkg::t_token_kind k0,
                                     output lts_pkg::t_token_kind k1,
                                     output logic [lts_pkg::OUT_LINE_BITS-1:0] ln);
        lts_pkg::t_token_kind kk [0:1];
        int                   n;
        bit                   ends;
        n     = 0;
        ends  = e || c == lts_pkg::CH_NUL;
        kk[0] = lts_pkg::TK_END;
        kk[1] = lts_pkg::TK_END;
        k0    = lts_pkg::TK_END;
        k1    = lts_pkg::TK_END;
        ln    = lts_pkg::OUT_LINE_BITS'(line_ct);
        // close a pending integer, identifier or colon
        case (scan_st)
            lts_pkg::ST_INT: begin
                if (!ends && is_digit(c))
                    return 0;
                kk[n] = lts_pkg::TK_INT;
                n = n + 1;
                scan_st = lts_pkg::ST_IDLE;
            end
            lts_pkg::ST_IDENT: begin
                if (!ends && (is_letter(c) || is_digit(c)))
                    return 0;
                kk[n] = lts_pkg::TK_IDENT;
                n = n + 1;
                scan_st = lts_pkg::ST_IDLE;
            end
            lts_pkg::ST_COLON: begin
                scan_st = lts_pkg::ST_IDLE;
                if (!ends && c == lts_pkg::CH_EQUAL) begin
                    k0 = lts_pkg::TK_ASSIGN;
                    return 1;
                end
                kk[n] = lts_pkg::TK_ERROR;
                n = n + 1;
            end
            default: ;
        endcase
        // the byte again, from idle
        if (ends) begin
            kk[n] = lts_pkg::TK_END;
            n = n + 1;
            scan_st = lts_pkg::ST_IDLE;
            line_ct = lts_pkg::LINE_ONE;
        end else if (c == lts_pkg::CH_SPACE ||
                     (c >= lts_pkg::CH_TAB && c <= lts_pkg::CH_CR)) begin
            if (c == lts_pkg::CH_NL && line_ct != lts_pkg::LINE_MAX)
                line_ct = line_ct + lts_pkg::LINE_ONE;
        end else if (is_digit(c)) begin
            scan_st = lts_pkg::ST_INT;
        end else if (is_letter(c)) begin
            scan_st = lts_pkg::ST_IDENT;
        end else if (c == lts_pkg::CH_COLON) begin
            scan_st = lts_pkg::ST_COLON;
        end else begin
            case (c)
                lts_pkg::CH_PLUS:  kk[n] = lts_pkg::TK_PLUS;
                lts_pkg::CH_STAR:  kk[n] = lts_pkg::TK_TIMES;
                lts_pkg::CH_LPAR:  kk[n] = lts_pkg::TK_LPAREN;
                lts_pkg::CH_RPAR:  kk[n] = lts_pkg::TK_RPAREN;
                lts_pkg::CH_SEMI:  kk[n] = lts_pkg::TK_SEMI;
                lts_pkg::CH_MINUS: kk[n] = lts_pkg::TK_MINUS;
                default:           kk[n] = lts_pkg::TK_ERROR;
            endcase
            n = n + 1;
        end
        k0 = kk[0];
        k1 = kk[1];
        return n;
    endfunction

    // queue the tokens one byte should cause; a typed row supplies its own
    function automatic void predict_push(input logic [7:0] c, input logic e,
                                         input logic typed,
                                         input lts_pkg::t_token_kind tk,
                                         input logic [lts_pkg::OUT_LINE_BITS-1:0] tl);
        int                                n;
        lts_pkg::t_token_kind              k0;
        lts_pkg::t_token_kind              k1;
        logic [lts_pkg::OUT_LINE_BITS-1:0] ln;
        n = scan_byte(c, e, k0, k1, ln);
        if (typed) begin
            pending_tokens.push_back('{tk, tl, 1'b1});
        end else begin
            if (n > 0)
                pending_tokens.push_back('{k0, ln, n == 1});
            if (n > 1)
                pending_tokens.push_back('{k1, ln, 1'b1});
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches = mismatches + 1;
    endtask

    // one byte transaction, with random idle cycles ahead of it while source idling is on
    task automatic drive_byte(input logic [7:0] c, input logic e);
        while (src_idle_en && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_char_code    <= c;
        i_end_of_input <= e;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic feed_byte(input logic [7:0] c, input logic e);
        predict_push(c, e, 1'b0, lts_pkg::TK_END, '0);
        drive_byte(c, e);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0)
            return lts_pkg::CH_LO_A + 8'($urandom_range(25));
        return lts_pkg::CH_UP_A + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return lts_pkg::CH_0 + 8'($urandom_range(9));
    endfunction

    // one random lexeme: mostly well-formed tokens, some noise and broken ones
    task automatic feed_lexeme();
        int pick;
        int len;
        pick = $urandom_range(99);
        if (pick < 22) begin
            feed_byte(rand_letter(), 1'b0);
            len = $urandom_range(6);
            repeat (len)
                feed_byte(($urandom_range(2) == 0) ? rand_digit() : rand_letter(), 1'b0);
        end else if (pick < 40) begin
            len = $urandom_range(1, 5);
            repeat (len)
                feed_byte(rand_digit(), 1'b0);
        end else if (pick < 48) begin
            feed_byte(lts_pkg::CH_COLON, 1'b0);
            feed_byte(lts_pkg::CH_EQUAL, 1'b0);
        end else if (pick < 64) begin
            case ($urandom_range(5))
                0:       feed_byte(lts_pkg::CH_PLUS, 1'b0);
                1:       feed_byte(lts_pkg::CH_STAR, 1'b0);
                2:       feed_byte(lts_pkg::CH_LPAR, 1'b0);
                3:       feed_byte(lts_pkg::CH_RPAR, 1'b0);
                4:       feed_byte(lts_pkg::CH_SEMI, 1'b0);
                default: feed_byte(lts_pkg::CH_MINUS, 1'b0);
            endcase
        end else if (pick < 76) begin
            // whitespace, newline most often; vertical tab and form feed too
            case ($urandom_range(5))
                0, 1:    feed_byte(lts_pkg::CH_NL, 1'b0);
                2:       feed_byte(lts_pkg::CH_SPACE, 1'b0);
                3:       feed_byte(lts_pkg::CH_TAB, 1'b0);
                4:       feed_byte(lts_pkg::CH_CR, 1'b0);
                default: feed_byte(8'($urandom_range(11, 12)), 1'b0);
            endcase
        end else if (pick < 80) begin
            // colon with whatever comes next
            feed_byte(lts_pkg::CH_COLON, 1'b0);
        end else if (pick < 90) begin
            feed_byte(8'($urandom_range(255)), 1'b0);
        end else if (pick < 93) begin
            // end mark; the byte beside it is don't-care
            feed_byte(8'($urandom_range(255)), 1'b1);
        end else if (pick < 95) begin
            feed_byte(lts_pkg::CH_NUL, 1'b0);
        end else begin
            feed_byte(8'($urandom_range(128, 255)), 1'b0);
        end
    endtask

    // token sink: random stalls unless switched off
    always @(posedge i_clk) begin
        if (snk_idle_en)
            i_ready <= ($urandom_range(99) >= 18);
        else
            i_ready <= 1'b1;
    end

    // every accepted token against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("token kind %0d line %0d with none pending",
                                          o_token_kind, o_line_number));
            end else begin
                want = pending_tokens.pop_front();
                if (o_token_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d",
                                              o_token_kind, want.kind));
                if (o_line_number !== want.line)
                    report_mismatch($sformatf("line %0d, want %0d",
                                              o_line_number, want.line));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_char_code    <= '0;
        i_end_of_input <= 1'b0;
        mismatches     = 0;
        bytes_sent     = 0;
        src_idle_en    = 1'b1;
        snk_idle_en    = 1'b1;
        scan_st        = lts_pkg::ST_IDLE;
        line_ct        = lts_pkg::LINE_ONE;

        // single-character tokens and error codes after reset, then pending
        // tokens closed by delimiters, lone colons and both kinds of end
        directed_rows = '{
            '{lts_pkg::CH_PLUS,  1'b0, 1'b1, lts_pkg::TK_PLUS,   16'd1},
            '{lts_pkg::CH_STAR,  1'b0, 1'b1, lts_pkg::TK_TIMES,  16'd1},
            '{lts_pkg::CH_LPAR,  1'b0, 1'b1, lts_pkg::TK_LPAREN, 16'd1},
            '{lts_pkg::CH_RPAR,  1'b0, 1'b1, lts_pkg::TK_RPAREN, 16'd1},
            '{lts_pkg::CH_SEMI,  1'b0, 1'b1, lts_pkg::TK_SEMI,   16'd1},
            '{lts_pkg::CH_MINUS, 1'b0, 1'b1, lts_pkg::TK_MINUS,  16'd1},
            '{8'hFF,             1'b0, 1'b1, lts_pkg::TK_ERROR,  16'd1},
            '{8'h80,             1'b0, 1'b1, lts_pkg::TK_ERROR,  16'd1},
            '{"@",               1'b0, 1'b1, lts_pkg::TK_ERROR,  16'd1},
            '{lts_pkg::CH_NL,    1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_LO_A,  1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_UP_Z,  1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_9,     1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_LPAR,  1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_0,     1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_SPACE, 1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_COLON, 1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_EQUAL, 1'b0, 1'b1, lts_pkg::TK_ASSIGN, 16'd2},
            '{lts_pkg::CH_COLON, 1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_COLON, 1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{"x",               1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_NUL,   1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_9,     1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_0,     1'b1, 1'b0, lts_pkg::TK_END,    16'd0},
            '{lts_pkg::CH_COLON, 1'b0, 1'b0, lts_pkg::TK_END,    16'd0},
            '{8'hFF,             1'b1, 1'b0, lts_pkg::TK_END,    16'd0},
            '{8'h00,             1'b1, 1'b1, lts_pkg::TK_END,    16'd1}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            predict_push(directed_rows[r].chr, directed_rows[r].eoi,
                         directed_rows[r].typed, directed_rows[r].kind,
                         directed_rows[r].line);
            drive_byte(directed_rows[r].chr, directed_rows[r].eoi);
        end

        // random lexemes; a stretch in the middle runs with no idling at all
        while (bytes_sent < N_DIRECTED + N_RANDOM) begin
            src_idle_en = (bytes_sent < N_DIRECTED + 250) ||
                          (bytes_sent >= N_DIRECTED + 400);
            snk_idle_en = src_idle_en;
            feed_lexeme();
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;

        // pending identifier across a newline, then a mix of closing bytes
        feed_byte(lts_pkg::CH_LO_A, 1'b0);
        feed_byte(lts_pkg::CH_NL, 1'b0);
        feed_byte(lts_pkg::CH_PLUS, 1'b0);
        feed_byte(lts_pkg::CH_NL, 1'b0);
        feed_byte(lts_pkg::CH_9, 1'b0);
        feed_byte(lts_pkg::CH_COLON, 1'b0);
        feed_byte(lts_pkg::CH_SEMI, 1'b0);
        feed_byte(8'hFF, 1'b1);
        // back on line one after the end mark
        repeat (30)
            feed_lexeme();

        i_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
        // trailing cycles to catch any extra token
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // an expectation left over at the end shows up as a timeout failure
endmodule

`default_nettype wire
